/* src/largest_empty_square_finder_top_defines.svh */
// Assertion macros used by the RTL core of the largest empty square finder.
`ifndef LARGEST_EMPTY_SQUARE_FINDER_TOP_DEFINES_SVH
`define LARGEST_EMPTY_SQUARE_FINDER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LESF_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LESF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/lesf_pkg.sv */
package lesf_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;
    localparam int COUNT_W  = 11;
    localparam int POS_W    = 10;
    localparam int CHAR_W   = 8;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int RES_W    = 32;

    localparam logic [COUNT_W-1:0] EMPTY_CHAR_RESET = COUNT_W'(46);

    typedef enum logic [1:0] {
        REG_ROW_COUNT  = 2'd0,
        REG_COL_COUNT  = 2'd1,
        REG_EMPTY_CHAR = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [COUNT_W-1:0] rows;
        logic [COUNT_W-1:0] cols;
        logic [CHAR_W-1:0]  empty_char;
        logic               restart;
    } cfg_t;

    typedef struct packed {
        logic [POS_W-1:0]   square_col;
        logic [POS_W-1:0]   square_row;
        logic [COUNT_W-1:0] square_size;
    } result_t;

    function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v,
                                                       input logic [COUNT_W-1:0] lim);
        logic [COUNT_W-1:0] r;
        if (v == '0)
        begin
            r = COUNT_W'(1);
        end
        else if (v > lim)
        begin
            r = lim;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

/* src/largest_empty_square_finder_top.sv */
// Largest empty square finder.
// Cells of a character grid arrive on the slave stream in raster order, one per
// transfer, eight bits each. Cells equal to the empty character are empty. After
// the last cell of a frame one result leaves on the master stream: the side of
// the first strictly largest empty square, and its top row and left column, all
// zero when the frame has no empty cell.
// Row count, column count and empty character are set through the APB port;
// any write to a known register starts a new frame. The user must make these
// writes only while idle; the block does not enforce it. One cell is accepted
// every cycle unless input stalls. The line store is a single-port-read,
// single-port-write memory read in the cycle before stage 1 computes the side.
// The output holds the result until taken and a skid entry holds one more; input
// stalls only while the skid entry is full, or while a frame result is being
// formed and the receiver is holding the output register.
// Reset sets rows and columns to one and the empty character to a full stop,
// and clears position and best square. The line store is not cleared; each
// entry is used only after it has been written within a frame.
module largest_empty_square_finder_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lesf_pkg::ADDR_W-1:0]   paddr,
    input  logic [lesf_pkg::DATA_W-1:0]   pwdata,
    output logic [lesf_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lesf_pkg::CHAR_W-1:0]   s_tdata,  // cell_char
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lesf_pkg::RES_W-1:0]    m_tdata   // square_size, square_row, square_col
);
    import lesf_pkg::*;

    logic [COUNT_W-1:0] row_count_reg;
    logic [COUNT_W-1:0] col_count_reg;
    logic [CHAR_W-1:0]  empty_char_reg;
    logic               wr_en;
    reg_idx_t           reg_idx;
    logic               restart;
    cfg_t               cfg;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        restart = 1'b0;
        unique case (reg_idx)
            REG_ROW_COUNT, REG_COL_COUNT, REG_EMPTY_CHAR:
            begin
                restart = wr_en;
            end
            default:
            begin
                restart = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg  <= COUNT_W'(1);
            col_count_reg  <= COUNT_W'(1);
            empty_char_reg <= EMPTY_CHAR_RESET[CHAR_W-1:0];
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_ROW_COUNT:  row_count_reg  <= pwdata[COUNT_W-1:0];
                REG_COL_COUNT:  col_count_reg  <= pwdata[COUNT_W-1:0];
                REG_EMPTY_CHAR: empty_char_reg <= pwdata[CHAR_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ROW_COUNT:  prdata = DATA_W'(row_count_reg);
            REG_COL_COUNT:  prdata = DATA_W'(col_count_reg);
            REG_EMPTY_CHAR: prdata = DATA_W'(empty_char_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.rows       = clamp_count(row_count_reg, COUNT_W'(MAX_ROWS));
    assign cfg.cols       = clamp_count(col_count_reg, COUNT_W'(MAX_COLS));
    assign cfg.empty_char = empty_char_reg;
    assign cfg.restart    = restart;

    lesf_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );
endmodule

/* src/lesf_core.sv */
`include "largest_empty_square_finder_top_defines.svh"

module lesf_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  lesf_pkg::cfg_t               cfg,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [lesf_pkg::CHAR_W-1:0]  s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [lesf_pkg::RES_W-1:0]   m_tdata
);
    import lesf_pkg::*;

    logic [COUNT_W-1:0] line_mem [MAX_COLS];
    logic [COUNT_W-1:0] up_reg;

    logic [POS_W-1:0]   col_pos_reg;
    logic [POS_W-1:0]   row_pos_reg;
    logic               accept;
    logic               row_end;
    logic               frame_end;

    logic               s1_valid_reg;
    logic               s1_last_reg;
    logic               s1_empty_reg;
    logic [POS_W-1:0]   s1_col_reg;
    logic [POS_W-1:0]   s1_row_reg;

    logic [COUNT_W-1:0] left_reg;
    logic [COUNT_W-1:0] diag_reg;
    logic [COUNT_W-1:0] best_size_reg;
    logic [POS_W-1:0]   best_top_reg;
    logic [POS_W-1:0]   best_left_reg;

    logic [COUNT_W-1:0] min_ul;
    logic [COUNT_W-1:0] min3;
    logic [COUNT_W-1:0] side;
    logic               better;
    logic [COUNT_W-1:0] top_wide;
    logic [COUNT_W-1:0] left_wide;
    result_t            best_next;
    logic               res_in;

    logic               out_valid_reg;
    result_t            out_reg;
    logic               skid_valid_reg;
    result_t            skid_reg;
    logic               out_free;

    // Stage 0: take the cell, step the raster position and read the row above.
    assign s_tready  = !skid_valid_reg && !(res_in && !out_free);
    assign accept    = s_tvalid && s_tready;
    assign row_end   = ({1'b0, col_pos_reg} == cfg.cols - COUNT_W'(1));
    assign frame_end = row_end && ({1'b0, row_pos_reg} == cfg.rows - COUNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s1_last_reg  <= accept && frame_end;
            if (cfg.restart)
            begin
                col_pos_reg <= '0;
                row_pos_reg <= '0;
            end
            else if (accept)
            begin
                if (row_end)
                begin
                    col_pos_reg <= '0;
                    row_pos_reg <= frame_end ? '0 : row_pos_reg + POS_W'(1);
                end
                else
                begin
                    col_pos_reg <= col_pos_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            up_reg       <= line_mem[col_pos_reg];
            s1_col_reg   <= col_pos_reg;
            s1_row_reg   <= row_pos_reg;
            s1_empty_reg <= (s_tdata == cfg.empty_char);
        end
        if (s1_valid_reg)
        begin
            line_mem[s1_col_reg] <= side;
        end
    end

    // Stage 1: side of the square ending at this cell, and the running best.
    always_comb
    begin
        min_ul = (up_reg < left_reg) ? up_reg : left_reg;
        min3   = (diag_reg < min_ul) ? diag_reg : min_ul;
        if (!s1_empty_reg)
        begin
            side = '0;
        end
        else if (s1_row_reg == '0 || s1_col_reg == '0)
        begin
            side = COUNT_W'(1);
        end
        else
        begin
            side = min3 + COUNT_W'(1);
        end
        better    = s1_valid_reg && (side > best_size_reg);
        top_wide  = {1'b0, s1_row_reg} + COUNT_W'(1) - side;
        left_wide = {1'b0, s1_col_reg} + COUNT_W'(1) - side;
        if (better)
        begin
            best_next.square_size = side;
            best_next.square_row  = top_wide[POS_W-1:0];
            best_next.square_col  = left_wide[POS_W-1:0];
        end
        else
        begin
            best_next.square_size = best_size_reg;
            best_next.square_row  = best_top_reg;
            best_next.square_col  = best_left_reg;
        end
        res_in = s1_valid_reg && s1_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            diag_reg      <= '0;
            best_size_reg <= '0;
            best_top_reg  <= '0;
            best_left_reg <= '0;
        end
        else if (cfg.restart || res_in)
        begin
            left_reg      <= '0;
            diag_reg      <= '0;
            best_size_reg <= '0;
            best_top_reg  <= '0;
            best_left_reg <= '0;
        end
        else if (s1_valid_reg)
        begin
            left_reg      <= side;
            diag_reg      <= up_reg;
            best_size_reg <= best_next.square_size;
            best_top_reg  <= best_next.square_row;
            best_left_reg <= best_next.square_col;
        end
    end

    // Output register with one skid entry behind it.
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (res_in)
        begin
            if (out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_in)
        begin
            if (out_free)
            begin
                out_reg <= best_next;
            end
            else
            begin
                skid_reg <= best_next;
            end
        end
        else if (out_free && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = RES_W'(out_reg);

    `LESF_ASSERT_SAME(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg,
        "skid entry held while the output register is empty")
    `LESF_ASSERT_SAME(a_result_skid_free, clk, rst_n, res_in, !skid_valid_reg,
        "frame result arrived with the skid entry already full")
    `LESF_ASSERT_NEXT(a_result_shown, clk, rst_n, res_in, out_valid_reg,
        "frame result was not presented on the output")
    `LESF_ASSERT_SAME(a_line_no_clash, clk, rst_n,
        accept && s1_valid_reg && (cfg.cols != COUNT_W'(1)), col_pos_reg != s1_col_reg,
        "line store read and write hit the same column")
endmodule

/* dv/tb_largest_empty_square_finder_top.sv */
module tb_largest_empty_square_finder_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lesf_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam int RANDOM_CELLS = 1650;
    localparam int SETTLE       = 4;
    localparam int FILL_PCT     = 75;

    localparam logic [ADDR_W-1:0] ROWS_ADDR  = ADDR_W'(4 * REG_ROW_COUNT);
    localparam logic [ADDR_W-1:0] COLS_ADDR  = ADDR_W'(4 * REG_COL_COUNT);
    localparam logic [ADDR_W-1:0] EMPTY_ADDR = ADDR_W'(4 * REG_EMPTY_CHAR);
    // Slot after the last register; writes there must be ignored.
    localparam logic [ADDR_W-1:0] SPARE_ADDR = ADDR_W'(12);

    localparam logic [CHAR_W-1:0] DOT  = 8'd46;
    localparam logic [CHAR_W-1:0] WALL = 8'd35;

    typedef struct packed {
        logic               is_write;
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] value;
        logic [CHAR_W-1:0]  char_code;
        logic               typed;
        result_t            want;
    } step_row_t;

    logic                clk;
    logic                rst_n    = 1'b0;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ADDR_W-1:0]   paddr    = '0;
    logic [DATA_W-1:0]   pwdata   = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [CHAR_W-1:0]   s_tdata  = '0;  // cell_char
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [RES_W-1:0]    m_tdata;        // square_size, square_row, square_col

    logic [COUNT_W-1:0]  grid_rows;
    logic [COUNT_W-1:0]  grid_cols;
    logic [CHAR_W-1:0]   blank_char;
    logic [COUNT_W-1:0]  above_sides [MAX_COLS];
    logic [COUNT_W-1:0]  run_left;
    logic [COUNT_W-1:0]  run_diag;
    logic [POS_W-1:0]    cur_row;
    logic [POS_W-1:0]    cur_col;
    logic [COUNT_W-1:0]  top_side;
    logic [POS_W-1:0]    top_row;
    logic [POS_W-1:0]    top_col;

    result_t             pending_squares [$];
    int                  errors         = 0;
    int                  cycle_count    = 0;
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;

    largest_empty_square_finder_top uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic step_row_t write_row(input logic [ADDR_W-1:0] a,
                                            input logic [COUNT_W-1:0] v);
        step_row_t row;
        row          = '0;
        row.is_write = 1'b1;
        row.addr     = a;
        row.value    = v;
        return row;
    endfunction

    function automatic step_row_t cell_row(input logic [CHAR_W-1:0] ch);
        step_row_t row;
        row           = '0;
        row.char_code = ch;
        return row;
    endfunction

    function automatic step_row_t closing_row(input logic [CHAR_W-1:0] ch,
                                              input int sz, input int r, input int c);
        step_row_t row;
        row                  = '0;
        row.char_code        = ch;
        row.typed            = 1'b1;
        row.want.square_size = COUNT_W'(sz);
        row.want.square_row  = POS_W'(r);
        row.want.square_col  = POS_W'(c);
        return row;
    endfunction

    step_row_t directed_steps [34] = '{
        closing_row(DOT, 1, 0, 0),
        closing_row(WALL, 0, 0, 0),
        write_row(EMPTY_ADDR, 11'd0),
        closing_row(8'd0, 1, 0, 0),
        closing_row(8'd255, 0, 0, 0),
        write_row(EMPTY_ADDR, 11'd255),
        closing_row(8'd255, 1, 0, 0),
        write_row(ROWS_ADDR, 11'd0),
        write_row(COLS_ADDR, 11'd0),
        closing_row(8'd255, 1, 0, 0),
        write_row(ROWS_ADDR, 11'd3),
        write_row(COLS_ADDR, 11'd3),
        write_row(EMPTY_ADDR, 11'(DOT)),
        cell_row(WALL),
        cell_row(DOT),
        cell_row(DOT),
        cell_row(WALL),
        write_row(SPARE_ADDR, 11'h5A5),
        cell_row(DOT),
        cell_row(DOT),
        cell_row(DOT),
        cell_row(DOT),
        cell_row(DOT),
        write_row(ROWS_ADDR, 11'd1),
        cell_row(DOT),
        cell_row(WALL),
        closing_row(DOT, 1, 0, 0),
        write_row(ROWS_ADDR, 11'd2),
        write_row(COLS_ADDR, 11'd2),
        cell_row(DOT),
        cell_row(DOT),
        write_row(ROWS_ADDR, 11'd1),
        write_row(COLS_ADDR, 11'd1),
        closing_row(WALL, 0, 0, 0)
    };

    function automatic int fit_count(input logic [COUNT_W-1:0] v, input int lim);
        if (v == '0)
        begin
            return 1;
        end
        if (int'(v) > lim)
        begin
            return lim;
        end
        return int'(v);
    endfunction

    function automatic void clear_frame();
        run_left = '0;
        run_diag = '0;
        cur_row  = '0;
        cur_col  = '0;
        top_side = '0;
        top_row  = '0;
        top_col  = '0;
    endfunction

    function automatic void reset_grid_model();
        grid_rows  = COUNT_W'(1);
        grid_cols  = COUNT_W'(1);
        blank_char = EMPTY_CHAR_RESET[CHAR_W-1:0];
        foreach (above_sides[i])
        begin
            above_sides[i] = '0;
        end
        clear_frame();
    endfunction

    function automatic void apply_write(input logic [ADDR_W-1:0] a,
                                        input logic [DATA_W-1:0] d);
        case (a[3:2])
            REG_ROW_COUNT:  grid_rows  = d[COUNT_W-1:0];
            REG_COL_COUNT:  grid_cols  = d[COUNT_W-1:0];
            REG_EMPTY_CHAR: blank_char = d[CHAR_W-1:0];
            default:        return;
        endcase
        clear_frame();
    endfunction

    function automatic logic [DATA_W-1:0] register_value(input logic [ADDR_W-1:0] a);
        case (a[3:2])
            REG_ROW_COUNT:  return DATA_W'(grid_rows);
            REG_COL_COUNT:  return DATA_W'(grid_cols);
            REG_EMPTY_CHAR: return DATA_W'(blank_char);
            default:        return '0;
        endcase
    endfunction

    // Advances the square search by one cell; returns 1 when the frame closes.
    function automatic bit scan_cell(input logic [CHAR_W-1:0] ch, output result_t found);
        int rows;
        int cols;
        int col;
        int up;
        int side;
        int low;
        rows  = fit_count(grid_rows, MAX_ROWS);
        cols  = fit_count(grid_cols, MAX_COLS);
        found = '0;
        col   = int'(cur_col);
        if (col >= cols)
        begin
            col = 0;
        end
        up = int'(above_sides[col]);
        if (ch != blank_char)
        begin
            side = 0;
        end
        else if (cur_row == '0 || col == 0)
        begin
            side = 1;
        end
        else
        begin
            low = up;
            if (int'(run_left) < low)
            begin
                low = int'(run_left);
            end
            if (int'(run_diag) < low)
            begin
                low = int'(run_diag);
            end
            side = (low + 1) & 'h7FF;
        end
        if (side > int'(top_side))
        begin
            top_side = COUNT_W'(side);
            top_row  = POS_W'(int'(cur_row) + 1 - side);
            top_col  = POS_W'(col + 1 - side);
        end
        run_diag         = COUNT_W'(up);
        run_left         = COUNT_W'(side);
        above_sides[col] = COUNT_W'(side);
        if (col + 1 < cols)
        begin
            cur_col = POS_W'(col + 1);
            return 1'b0;
        end
        cur_col  = '0;
        run_left = '0;
        run_diag = '0;
        if (int'(cur_row) + 1 < rows)
        begin
            cur_row = cur_row + 1'b1;
            return 1'b0;
        end
        found.square_size = top_side;
        found.square_row  = top_row;
        found.square_col  = top_col;
        clear_frame();
        return 1'b1;
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 8)
        begin
            return '0;
        end
        if (r < 16)
        begin
            return COUNT_W'($urandom_range(12, 7));
        end
        return COUNT_W'($urandom_range(6, 1));
    endfunction

    task automatic set_mode(input int m);
        case (m % 4)
            0:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct  = 78;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 78;
            end
            default:
            begin
                send_idle_pct  = 32;
                recv_stall_pct = 32;
            end
        endcase
    endtask

    task automatic push_cell(input logic [CHAR_W-1:0] ch, output bit done,
                             output result_t found);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        done = scan_cell(ch, found);
    endtask

    task automatic send_cell(input logic [CHAR_W-1:0] ch);
        bit      done;
        result_t found;
        push_cell(ch, done, found);
        if (done)
        begin
            pending_squares.push_back(found);
        end
    endtask

    task automatic wait_quiet();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_squares.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= a;
        pwdata  <= d;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        apply_write(a, d);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_registers();
        logic [ADDR_W-1:0] a;
        logic [DATA_W-1:0] got;
        for (int r = REG_ROW_COUNT; r <= REG_EMPTY_CHAR; r++)
        begin
            a = ADDR_W'(4 * r);
            @(negedge clk);
            psel    <= 1'b1;
            pwrite  <= 1'b0;
            penable <= 1'b0;
            paddr   <= a;
            @(negedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready)
            begin
                @(posedge clk);
            end
            got = prdata;
            if (got !== register_value(a))
            begin
                $error("prdata at 0x%0h: expected 0x%0h, actual 0x%0h",
                       a, register_value(a), got);
                errors++;
            end
            @(negedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : square_check
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[$bits(result_t)-1:0];
            if (pending_squares.size() == 0)
            begin
                $error("square_size: expected no transfer, actual %0d", got.square_size);
                errors++;
            end
            else
            begin
                want = pending_squares.pop_front();
                if (got.square_size !== want.square_size)
                begin
                    $error("square_size: expected %0d, actual %0d",
                           want.square_size, got.square_size);
                    errors++;
                end
                if (got.square_row !== want.square_row)
                begin
                    $error("square_row: expected %0d, actual %0d",
                           want.square_row, got.square_row);
                    errors++;
                end
                if (got.square_col !== want.square_col)
                begin
                    $error("square_col: expected %0d, actual %0d",
                           want.square_col, got.square_col);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("tb_largest_empty_square_finder_top: errors");
            $finish;
        end
    end

    initial
    begin
        bit                 done;
        result_t            found;
        int                 phase;
        int                 cells_sent;
        int                 frames;
        int                 n;
        int                 cut;
        logic [COUNT_W-1:0] rows_w;
        logic [COUNT_W-1:0] cols_w;
        logic [CHAR_W-1:0]  ch;

        reset_grid_model();
        set_mode(0);
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        check_registers();

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].is_write)
            begin
                wait_quiet();
                apb_write(directed_steps[i].addr, DATA_W'(directed_steps[i].value));
            end
            else
            begin
                push_cell(directed_steps[i].char_code, done, found);
                if (directed_steps[i].typed)
                begin
                    pending_squares.push_back(directed_steps[i].want);
                end
                else if (done)
                begin
                    pending_squares.push_back(found);
                end
            end
        end

        phase      = 0;
        cells_sent = 0;
        while (cells_sent < RANDOM_CELLS)
        begin
            set_mode(phase);
            wait_quiet();
            if (phase == 3 || phase == 8)
            begin
                // One tall frame and one wide frame, each past the limit, with
                // the only empty cell at the far end.
                rows_w = (phase == 3) ? 11'd2047 : 11'd1;
                cols_w = (phase == 3) ? 11'd0 : 11'd1025;
                apb_write(ROWS_ADDR, DATA_W'(rows_w));
                apb_write(COLS_ADDR, DATA_W'(cols_w));
                apb_write(EMPTY_ADDR, DATA_W'($urandom_range(255)));
                check_registers();
                n = fit_count(grid_rows, MAX_ROWS) * fit_count(grid_cols, MAX_COLS);
                for (int k = 0; k < n; k++)
                begin
                    ch = (k == n - 1) ? blank_char
                                      : blank_char ^ CHAR_W'($urandom_range(255, 1));
                    send_cell(ch);
                    cells_sent++;
                end
            end
            else
            begin
                rows_w = pick_count();
                cols_w = pick_count();
                apb_write(ROWS_ADDR, ($urandom & ~32'h7FF) | DATA_W'(rows_w));
                apb_write(COLS_ADDR, ($urandom & ~32'h7FF) | DATA_W'(cols_w));
                case ($urandom_range(9))
                    0:       ch = 8'd0;
                    1:       ch = 8'd255;
                    default: ch = CHAR_W'($urandom_range(255));
                endcase
                apb_write(EMPTY_ADDR, ($urandom & ~32'hFF) | DATA_W'(ch));
                check_registers();
                n      = fit_count(grid_rows, MAX_ROWS) * fit_count(grid_cols, MAX_COLS);
                frames = $urandom_range(6, 2);
                for (int f = 0; f < frames; f++)
                begin
                    for (int k = 0; k < n; k++)
                    begin
                        if ($urandom_range(99) < FILL_PCT)
                        begin
                            ch = blank_char;
                        end
                        else
                        begin
                            ch = CHAR_W'($urandom_range(255));
                        end
                        send_cell(ch);
                        cells_sent++;
                    end
                    if ($urandom_range(5) == 0)
                    begin
                        wait_quiet();
                    end
                end
                // At random, a part frame is left behind for the next register write to abandon.
                if (n > 1 && $urandom_range(2) == 0)
                begin
                    cut = $urandom_range(n - 1, 1);
                    for (int k = 0; k < cut; k++)
                    begin
                        send_cell(($urandom_range(99) < FILL_PCT) ? blank_char
                                                                  : CHAR_W'($urandom));
                        cells_sent++;
                    end
                end
            end
            phase++;
        end

        wait_quiet();
        repeat (10) @(posedge clk);
        if (errors == 0)
        begin
            $display("tb_largest_empty_square_finder_top: clean");
        end
        else
        begin
            $display("tb_largest_empty_square_finder_top: errors");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/lesf_pkg.sv
src/lesf_core.sv
src/largest_empty_square_finder_top.sv
dv/tb_largest_empty_square_finder_top.sv
